>>> rtl/core/brmg_pkg.sv
// Shared types, codes and constants of the byte rescale and merge grid.
package brmg_pkg;

	// Configuration port geometry.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Byte code space and rescale constants.
	localparam int CODE_W    = 8;
	localparam int RND_HALF  = 32767;
	localparam int CLAMP_LO  = 3;
	localparam int CLAMP_HI  = 255;
	localparam int FRAC_W    = 16;

	// Queue depths between front, back and the result port.
	localparam int Q_DEPTH   = 4;
	localparam int Q_CW      = $clog2(Q_DEPTH + 1);
	localparam int OUT_DEPTH = 2;
	localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

	// Result payload: address and value.
	localparam int ADDR_OUT_W = 16;
	localparam int OUT_W      = ADDR_OUT_W + CODE_W;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IN_MISSING  = 3'd0,
		REG_IN_BAD      = 3'd1,
		REG_OUT_MISSING = 3'd2,
		REG_OUT_BAD     = 3'd3,
		REG_MERGE_MODE  = 3'd4,
		REG_GAIN        = 3'd5,
		REG_OFFSET      = 3'd6
	} reg_idx_t;

	// Item commands; the unused code behaves as a read.
	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_MERGE = 2'd1,
		CMD_READ  = 2'd2
	} cmd_t;

	// Merge rules; the unused code behaves as minimum.
	typedef enum logic [1:0] {
		MODE_SUM = 2'd0,
		MODE_MAX = 2'd1,
		MODE_MIN = 2'd2
	} mode_t;

	// Back end sequencer states.
	typedef enum logic {
		ST_IDLE  = 1'b0,
		ST_MERGE = 1'b1
	} state_t;

	// Configuration register set.
	typedef struct packed {
		logic [CODE_W-1:0] in_missing_code;
		logic [CODE_W-1:0] in_bad_code;
		logic [CODE_W-1:0] out_missing_code;
		logic [CODE_W-1:0] out_bad_code;
		logic [1:0]        merge_mode;
		logic signed [31:0] gain;
		logic signed [31:0] offset;
	} cfg_t;

endpackage

>>> rtl/core/brmg_fifo.sv
// Small register queue used between the front, the back and the result port.
module brmg_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [WIDTH-1:0]             push_data,
	input  logic                         pop,
	output logic [WIDTH-1:0]             pop_data,
	output logic                         empty,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	// A request moves only when there is room or data.
	assign do_push  = push && (count_q != CW'(DEPTH));
	assign do_pop   = pop && (count_q != '0);
	assign pop_data = mem_q[rd_ptr_q];
	assign empty    = (count_q == '0);
	assign count    = count_q;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> rtl/core/brmg_front.sv
// Front end: accepts requests, wraps the address and rescales merge bytes.
module brmg_front #(
	parameter int CELLS = 65536,
	parameter int AW    = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  brmg_pkg::cfg_t                 cfg,
	input  logic                           push,
	input  logic [1:0]                     cmd,
	input  logic [15:0]                    cell_index,
	input  logic [7:0]                     data_byte,
	input  logic [brmg_pkg::Q_CW-1:0]      q_count,
	output logic                           full,
	output logic                           q_push,
	output logic [AW+9:0]                  q_data
);

	// Reciprocal of the grid size for the address wrap; exact for 16-bit indexes.
	localparam longint unsigned RECIP_L =
		((64'd1 << 32) + 64'(CELLS) - 64'd1) / 64'(CELLS);
	localparam logic [32:0] RECIP    = 33'(RECIP_L);
	localparam logic [15:0] CELLS_LO = 16'(CELLS);
	localparam logic signed [41:0] T_LO = 42'(brmg_pkg::CLAMP_LO * 65536);
	localparam logic signed [41:0] T_HI = 42'((brmg_pkg::CLAMP_HI + 1) * 65536);
	localparam int Q_CWX = brmg_pkg::Q_CW + 1;

	logic                v_s1;
	logic [1:0]          cmd_s1;
	logic [15:0]         idx_s1;
	logic [7:0]          byte_s1;
	logic                missing_s1;
	logic                bad_s1;
	logic [48:0]         prodq_s1;
	logic signed [40:0]  prodg_s1;

	logic                accept;
	logic [48:0]         prodq;
	logic signed [40:0]  prodg;
	logic [15:0]         quot;
	logic [31:0]         qc;
	logic [15:0]         rem;
	logic [15:0]         addr16;
	logic signed [41:0]  t;
	logic [7:0]          scaled;
	logic [7:0]          rescaled;
	logic [7:0]          val;

	// Room is counted over the queue and the request in flight.
	assign full   = ((Q_CWX'(q_count) + Q_CWX'(v_s1)) >= Q_CWX'(brmg_pkg::Q_DEPTH));
	assign accept = push && !full;

	// Products formed at the input edge.
	assign prodq = 49'(cell_index) * 49'(RECIP);
	assign prodg = 41'($signed({1'b0, data_byte})) * 41'($signed(cfg.gain));

	// Stage one register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1     <= cmd;
			idx_s1     <= cell_index;
			byte_s1    <= data_byte;
			missing_s1 <= (data_byte == cfg.in_missing_code);
			bad_s1     <= (data_byte == cfg.in_bad_code);
			prodq_s1   <= prodq;
			prodg_s1   <= prodg;
		end
	end

	// Address wrap: index minus quotient times grid size.
	assign quot   = prodq_s1[47:32];
	assign qc     = quot * CELLS_LO;
	assign rem    = idx_s1 - qc[15:0];
	assign addr16 = (CELLS >= 65536) ? idx_s1 : rem;

	// Rescale with rounding and clamping; missing wins over bad.
	assign t = 42'(prodg_s1) + 42'($signed(cfg.offset)) + 42'(brmg_pkg::RND_HALF);

	always_comb begin
		if (t < T_LO) begin
			scaled = 8'(brmg_pkg::CLAMP_LO);
		end else if (t >= T_HI) begin
			scaled = 8'(brmg_pkg::CLAMP_HI);
		end else begin
			scaled = t[23:16];
		end
		if (missing_s1) begin
			rescaled = cfg.out_missing_code;
		end else if (bad_s1) begin
			rescaled = cfg.out_bad_code;
		end else begin
			rescaled = scaled;
		end
		val = (cmd_s1 == brmg_pkg::CMD_MERGE) ? rescaled : byte_s1;
	end

	// Classified request into the work queue.
	assign q_push = v_s1;
	assign q_data = {cmd_s1, AW'(addr16), val};

endmodule

>>> rtl/core/brmg_back.sv
// Back end: read-modify-write of the grid memory and result generation.
module brmg_back #(
	parameter int CELLS = 65536,
	parameter int AW    = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  brmg_pkg::cfg_t                 cfg,
	input  logic                           q_empty,
	input  logic [AW+9:0]                  q_data,
	output logic                           q_pop,
	input  logic [brmg_pkg::OUT_CW-1:0]    out_count,
	output logic                           out_push,
	output logic [brmg_pkg::OUT_W-1:0]     out_data
);

	logic [7:0]        grid_mem [CELLS];
	logic [7:0]        rd_q;
	logic [1:0]        cmd_q;
	logic [AW-1:0]     addr_q;
	logic [7:0]        val_q;

	brmg_pkg::state_t  state_q;
	brmg_pkg::state_t  state_d;
	logic              start;
	logic              wr_en;
	logic [7:0]        merged;
	logic [7:0]        new_val;
	logic              c_ok;
	logic              v_ok;

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= brmg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and strobes.
	always_comb begin
		state_d  = state_q;
		start    = 1'b0;
		out_push = 1'b0;
		unique case (state_q)
			brmg_pkg::ST_IDLE: begin
				if (!q_empty && (out_count < brmg_pkg::OUT_CW'(brmg_pkg::OUT_DEPTH))) begin
					start   = 1'b1;
					state_d = brmg_pkg::ST_MERGE;
				end
			end
			brmg_pkg::ST_MERGE: begin
				out_push = 1'b1;
				state_d  = brmg_pkg::ST_IDLE;
			end
			default: begin
				state_d = brmg_pkg::ST_IDLE;
			end
		endcase
	end

	assign q_pop = start;

	// Request taken from the queue.
	always_ff @(posedge clk) begin
		if (start) begin
			cmd_q  <= q_data[AW+9:AW+8];
			addr_q <= q_data[AW+7:8];
			val_q  <= q_data[7:0];
		end
	end

	// Merge of the stored cell with the rescaled byte.
	assign c_ok = (rd_q >= 8'(brmg_pkg::CLAMP_LO));
	assign v_ok = (val_q >= 8'(brmg_pkg::CLAMP_LO));

	always_comb begin
		case (cfg.merge_mode)
			brmg_pkg::MODE_SUM: begin
				if (c_ok && v_ok) begin
					merged = rd_q + val_q;
				end else if (!c_ok && v_ok) begin
					merged = val_q;
				end else begin
					merged = rd_q;
				end
			end
			brmg_pkg::MODE_MAX: begin
				merged = (rd_q <= val_q) ? val_q : rd_q;
			end
			default: begin
				merged = (!c_ok || (rd_q > val_q)) ? val_q : rd_q;
			end
		endcase
	end

	// Value after the operation and whether it goes back to memory.
	always_comb begin
		case (cmd_q)
			brmg_pkg::CMD_LOAD: begin
				new_val = val_q;
				wr_en   = out_push;
			end
			brmg_pkg::CMD_MERGE: begin
				new_val = merged;
				wr_en   = out_push;
			end
			default: begin
				new_val = rd_q;
				wr_en   = 1'b0;
			end
		endcase
	end

	// Grid memory: one read at start and, for loads and merges, one write at the end of the request.
	always_ff @(posedge clk) begin
		if (start) begin
			rd_q <= grid_mem[q_data[AW+7:8]];
		end
		if (wr_en) begin
			grid_mem[addr_q] <= new_val;
		end
	end

	assign out_data = {brmg_pkg::ADDR_OUT_W'(addr_q), new_val};

endmodule

>>> rtl/core/byte_rescale_merge_grid.sv
// Top level of the byte rescale and merge grid: configuration and block wiring.
// With empty queues a request passes the front stage register, the work queue, the back end
// idle and merge states and the result queue before its result shows on the result ports.
// The back end reads and then writes the grid memory for one request at a time.
// Reset: asynchronous, active low; queues empty, registers take their reset values.
// Grid contents are not cleared by reset and are undefined until loaded.
module byte_rescale_merge_grid #(
	parameter int CELLS = 65536
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [brmg_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [brmg_pkg::CFG_DATA_W-1:0]   wr_data,
	input  logic                              push,
	output logic                              full,
	input  logic [1:0]                        cmd,
	input  logic [15:0]                       cell_index,
	input  logic [7:0]                        data_byte,
	output logic                              empty,
	input  logic                              pop,
	output logic [15:0]                       cell_addr,
	output logic [7:0]                        cell_value
);

	localparam int AW     = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int ITEM_W = AW + 10;

	brmg_pkg::cfg_t                cfg_q;
	logic                          wq_push;
	logic [ITEM_W-1:0]             wq_wdata;
	logic                          wq_pop;
	logic [ITEM_W-1:0]             wq_rdata;
	logic                          wq_empty;
	logic [brmg_pkg::Q_CW-1:0]     wq_count;
	logic                          rq_push;
	logic [brmg_pkg::OUT_W-1:0]    rq_wdata;
	logic [brmg_pkg::OUT_W-1:0]    rq_rdata;
	logic [brmg_pkg::OUT_CW-1:0]   rq_count;

	// Configuration registers; writes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.in_missing_code  <= 8'd0;
			cfg_q.in_bad_code      <= 8'd1;
			cfg_q.out_missing_code <= 8'd0;
			cfg_q.out_bad_code     <= 8'd1;
			cfg_q.merge_mode       <= brmg_pkg::MODE_MAX;
			cfg_q.gain             <= 32'sd65536;
			cfg_q.offset           <= 32'sd0;
		end else if (wr_en) begin
			unique case (brmg_pkg::reg_idx_t'(wr_index))
				brmg_pkg::REG_IN_MISSING:  cfg_q.in_missing_code  <= wr_data[7:0];
				brmg_pkg::REG_IN_BAD:      cfg_q.in_bad_code      <= wr_data[7:0];
				brmg_pkg::REG_OUT_MISSING: cfg_q.out_missing_code <= wr_data[7:0];
				brmg_pkg::REG_OUT_BAD:     cfg_q.out_bad_code     <= wr_data[7:0];
				brmg_pkg::REG_MERGE_MODE:  cfg_q.merge_mode       <= wr_data[1:0];
				brmg_pkg::REG_GAIN:        cfg_q.gain             <= $signed(wr_data);
				brmg_pkg::REG_OFFSET:      cfg_q.offset           <= $signed(wr_data);
				default: begin
				end
			endcase
		end
	end

	// Front end: acceptance and classification.
	brmg_front #(
		.CELLS(CELLS),
		.AW(AW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.push(push),
		.cmd(cmd),
		.cell_index(cell_index),
		.data_byte(data_byte),
		.q_count(wq_count),
		.full(full),
		.q_push(wq_push),
		.q_data(wq_wdata)
	);

	// Work queue between front and back.
	brmg_fifo #(
		.WIDTH(ITEM_W),
		.DEPTH(brmg_pkg::Q_DEPTH)
	) u_work_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(wq_push),
		.push_data(wq_wdata),
		.pop(wq_pop),
		.pop_data(wq_rdata),
		.empty(wq_empty),
		.count(wq_count)
	);

	// Back end: grid memory update.
	brmg_back #(
		.CELLS(CELLS),
		.AW(AW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_empty(wq_empty),
		.q_data(wq_rdata),
		.q_pop(wq_pop),
		.out_count(rq_count),
		.out_push(rq_push),
		.out_data(rq_wdata)
	);

	// Result queue toward the consumer.
	brmg_fifo #(
		.WIDTH(brmg_pkg::OUT_W),
		.DEPTH(brmg_pkg::OUT_DEPTH)
	) u_result_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(rq_push),
		.push_data(rq_wdata),
		.pop(pop),
		.pop_data(rq_rdata),
		.empty(empty),
		.count(rq_count)
	);

	assign cell_addr  = rq_rdata[brmg_pkg::OUT_W-1:brmg_pkg::CODE_W];
	assign cell_value = rq_rdata[brmg_pkg::CODE_W-1:0];

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the byte rescale and merge grid.
`timescale 1ns / 1ps

module tb;

	// Unlisted codes: the spare command and mode act as aliases; a spare register write is dropped.
	localparam logic [1:0]                     CMD_SPARE  = 2'd3;
	localparam logic [1:0]                     MODE_SPARE = 2'd3;
	localparam logic [brmg_pkg::CFG_IDX_W-1:0] REG_SPARE  = 3'd7;

	localparam int GRID_CELLS     = 65536;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_ITEMS    = 106;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] index;
		logic [7:0]  data;
		bit          drain;
	} grid_req_t;

	typedef struct packed {
		logic [15:0] addr;
		logic [7:0]  value;
	} grid_result_t;

	logic                            clk;
	logic                            arst_n     = 1'b0;
	logic                            wr_en      = 1'b0;
	logic [brmg_pkg::CFG_IDX_W-1:0]  wr_index   = '0;
	logic [brmg_pkg::CFG_DATA_W-1:0] wr_data    = '0;
	logic                            push       = 1'b0;
	logic                            full;
	logic [1:0]                      cmd        = '0;
	logic [15:0]                     cell_index = '0;
	logic [7:0]                      data_byte  = '0;
	logic                            empty;
	logic                            pop        = 1'b0;
	logic [15:0]                     cell_addr;
	logic [7:0]                      cell_value;

	byte_rescale_merge_grid dut (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.push(push), .full(full), .cmd(cmd), .cell_index(cell_index), .data_byte(data_byte),
		.empty(empty), .pop(pop), .cell_addr(cell_addr), .cell_value(cell_value)
	);

	// Predictor state: settings and the grid contents as the block should hold them.
	brmg_pkg::cfg_t cfg_model;
	bit [7:0]       grid_model [0:GRID_CELLS-1];
	grid_result_t   expected_cells[$];

	// Stimulus bookkeeping: which cells have been loaded so far.
	bit           cell_loaded [0:GRID_CELLS-1];
	logic [15:0]  loaded_cells[$];
	grid_req_t    request_backlog[$];
	grid_req_t    cur_req;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int fail_cnt       = 0;
	int results_seen   = 0;
	int quiet_cycles   = 0;
	int phases_run     = 0;
	int loads_done     = 0;
	int merges_done    = 0;
	int reads_done     = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Map a raw input byte into the output code space.
	function automatic logic [7:0] rescale_byte(logic [7:0] b);
		longint t;
		if (b == cfg_model.in_missing_code)
			return cfg_model.out_missing_code;
		if (b == cfg_model.in_bad_code)
			return cfg_model.out_bad_code;
		t = longint'(b) * longint'($signed(cfg_model.gain))
			+ longint'($signed(cfg_model.offset)) + longint'(brmg_pkg::RND_HALF);
		if (t < (longint'(brmg_pkg::CLAMP_LO) << brmg_pkg::FRAC_W))
			return 8'(brmg_pkg::CLAMP_LO);
		if (t >= (longint'(brmg_pkg::CLAMP_HI + 1) << brmg_pkg::FRAC_W))
			return 8'(brmg_pkg::CLAMP_HI);
		return t[brmg_pkg::FRAC_W+7:brmg_pkg::FRAC_W];
	endfunction

	// Combine a cell with a rescaled byte under the current merge rule.
	function automatic logic [7:0] merge_cell(logic [7:0] c, logic [7:0] v);
		case (cfg_model.merge_mode)
			brmg_pkg::MODE_SUM: begin
				if (c >= brmg_pkg::CLAMP_LO && v >= brmg_pkg::CLAMP_LO)
					return 8'(c + v);
				if (c < brmg_pkg::CLAMP_LO && v >= brmg_pkg::CLAMP_LO)
					return v;
				return c;
			end
			brmg_pkg::MODE_MAX: return (c <= v) ? v : c;
			default:  return (c < brmg_pkg::CLAMP_LO || c > v) ? v : c;
		endcase
	endfunction

	// Apply one accepted request to the grid copy and queue the cell it reports.
	function automatic void apply_request_to_grid(grid_req_t r);
		grid_result_t res;
		logic [15:0]  a;
		a = 16'(r.index % GRID_CELLS);
		case (r.cmd)
			brmg_pkg::CMD_LOAD: begin
				grid_model[a] = r.data;
				loads_done++;
			end
			brmg_pkg::CMD_MERGE: begin
				grid_model[a] = merge_cell(grid_model[a], rescale_byte(r.data));
				merges_done++;
			end
			default: reads_done++;
		endcase
		res.addr  = a;
		res.value = grid_model[a];
		expected_cells.push_back(res);
	endfunction

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			fail_cnt++;
		end
	endtask

	// Request driver: presents backlog entries with random gaps.
	always @(posedge clk) begin : request_driver
		bit go;
		go = 1'b0;
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full)
				apply_request_to_grid(cur_req);
			if (push && full) begin
				go = 1'b1;
			end else if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct
					&& !(request_backlog[0].drain && expected_cells.size() != 0)) begin
				cur_req = request_backlog.pop_front();
				go = 1'b1;
				cmd        <= cur_req.cmd;
				cell_index <= cur_req.index;
				data_byte  <= cur_req.data;
			end
			push <= go;
		end
	end

	// Result monitor: pops with random stalls and compares against the oldest prediction.
	always @(posedge clk) begin : result_monitor
		grid_result_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				results_seen++;
				if (expected_cells.size() == 0) begin
					$error("unexpected result: cell_addr %0h cell_value %0h", cell_addr, cell_value);
					fail_cnt++;
				end else begin
					want = expected_cells.pop_front();
					check_field("cell_addr", want.addr, cell_addr);
					check_field("cell_value", 16'(want.value), 16'(cell_value));
				end
			end
			pop <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog: the run is stuck when nothing moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("** byte_rescale_merge_grid: FAILED **");
			$finish;
		end
	end

	task automatic write_reg(logic [brmg_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		case (idx)
			brmg_pkg::REG_IN_MISSING:  cfg_model.in_missing_code  = val[7:0];
			brmg_pkg::REG_IN_BAD:      cfg_model.in_bad_code      = val[7:0];
			brmg_pkg::REG_OUT_MISSING: cfg_model.out_missing_code = val[7:0];
			brmg_pkg::REG_OUT_BAD:     cfg_model.out_bad_code     = val[7:0];
			brmg_pkg::REG_MERGE_MODE:  cfg_model.merge_mode       = val[1:0];
			brmg_pkg::REG_GAIN:        cfg_model.gain             = val;
			brmg_pkg::REG_OFFSET:      cfg_model.offset           = val;
			default: ;
		endcase
	endtask

	task automatic end_writes();
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	// Pick a new setting for every register, extremes included now and then.
	task automatic random_config();
		int pick;
		logic [31:0] g, o;
		write_reg(brmg_pkg::REG_IN_MISSING, $urandom_range(255));
		write_reg(brmg_pkg::REG_IN_BAD, ($urandom_range(4) == 0) ?
			32'(cfg_model.in_missing_code) : $urandom_range(255));
		write_reg(brmg_pkg::REG_OUT_MISSING,
			$urandom_range(1) ? $urandom_range(2) : $urandom_range(255));
		write_reg(brmg_pkg::REG_OUT_BAD,
			$urandom_range(1) ? $urandom_range(2) : $urandom_range(255));
		write_reg(brmg_pkg::REG_MERGE_MODE, $urandom_range(3));
		pick = $urandom_range(9);
		case (pick)
			5:       g = -$urandom_range(32'h18000, 32'h4000);
			6:       g = 32'h8000_0000;
			7:       g = 32'h7FFF_FFFF;
			8:       g = '0;
			9:       g = $urandom();
			default: g = $urandom_range(32'h18000, 32'h4000);
		endcase
		write_reg(brmg_pkg::REG_GAIN, g);
		pick = $urandom_range(9);
		case (pick)
			6:       o = 32'h8000_0000;
			7:       o = 32'h7FFF_FFFF;
			8:       o = '0;
			9:       o = $urandom();
			default: o = 32'($urandom_range(32'h50_0000)) - 32'h14_0000;
		endcase
		write_reg(brmg_pkg::REG_OFFSET, o);
		if ($urandom_range(3) == 0)
			write_reg(REG_SPARE, $urandom());
		end_writes();
	endtask

	task automatic queue_item(logic [1:0] c, logic [15:0] idx, logic [7:0] d, bit drain);
		grid_req_t r;
		r.cmd   = c;
		r.index = idx;
		r.data  = d;
		r.drain = drain;
		if (c == brmg_pkg::CMD_LOAD && !cell_loaded[idx]) begin
			cell_loaded[idx] = 1'b1;
			loaded_cells.push_back(idx);
		end
		request_backlog.push_back(r);
	endtask

	// Favor recently loaded cells so that merges pile up on the same cells.
	function automatic logic [15:0] pick_loaded();
		int n = loaded_cells.size();
		if (n > 16 && $urandom_range(99) < 60)
			return loaded_cells[n - 1 - $urandom_range(15)];
		return loaded_cells[$urandom_range(n - 1)];
	endfunction

	function automatic logic [7:0] rand_input_byte();
		int pick = $urandom_range(9);
		if (pick < 2)
			return cfg_model.in_missing_code;
		if (pick == 2)
			return cfg_model.in_bad_code;
		return 8'($urandom());
	endfunction

	task automatic add_random_item(bit drain);
		int r;
		logic [15:0] a;
		logic [7:0] d;
		r = $urandom_range(99);
		if (loaded_cells.size() < 8 || r < 25) begin
			a = ($urandom_range(1) || loaded_cells.size() == 0) ? 16'($urandom()) : pick_loaded();
			d = ($urandom_range(4) == 0) ? 8'($urandom_range(2)) : 8'($urandom());
			queue_item(brmg_pkg::CMD_LOAD, a, d, drain);
		end else if (r < 75) begin
			queue_item(brmg_pkg::CMD_MERGE, pick_loaded(), rand_input_byte(), drain);
		end else if (r < 95) begin
			queue_item(brmg_pkg::CMD_READ, pick_loaded(), 8'($urandom()), drain);
		end else begin
			queue_item(CMD_SPARE, pick_loaded(), 8'($urandom()), drain);
		end
	endtask

	// Let the backlog and every outstanding result drain, then let the block settle before the next phase.
	task automatic wait_drained();
		while (request_backlog.size() != 0 || push || expected_cells.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		phases_run++;
	endtask

	// Stimulus: directed phases first, then random phases under varied settings and idling.
	initial begin : stimulus
		int p;
		cfg_model.in_missing_code  = 8'd0;
		cfg_model.in_bad_code      = 8'd1;
		cfg_model.out_missing_code = 8'd0;
		cfg_model.out_bad_code     = 8'd1;
		cfg_model.merge_mode       = brmg_pkg::MODE_MAX;
		cfg_model.gain             = 32'd65536;
		cfg_model.offset           = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset settings: corner addresses and bytes, every command, missing and bad input.
		queue_item(brmg_pkg::CMD_LOAD, 16'h0000, 8'h00, 1'b0);
		queue_item(brmg_pkg::CMD_LOAD, 16'hFFFF, 8'hFF, 1'b0);
		queue_item(brmg_pkg::CMD_LOAD, 16'hAAAA, 8'h55, 1'b0);
		queue_item(brmg_pkg::CMD_LOAD, 16'h5555, 8'hAA, 1'b0);
		queue_item(brmg_pkg::CMD_READ, 16'h0000, 8'h00, 1'b0);
		queue_item(CMD_SPARE, 16'hFFFF, 8'hFF, 1'b0);
		queue_item(brmg_pkg::CMD_MERGE, 16'h5555, 8'hFF, 1'b0);
		queue_item(brmg_pkg::CMD_MERGE, 16'h0000, 8'h00, 1'b0);
		queue_item(brmg_pkg::CMD_MERGE, 16'h0000, 8'h01, 1'b0);
		queue_item(brmg_pkg::CMD_MERGE, 16'hAAAA, 8'h80, 1'b0);
		wait_drained();

		// Sum mode, largest gain and most negative offset, missing code equal to bad code.
		write_reg(brmg_pkg::REG_MERGE_MODE, 32'(brmg_pkg::MODE_SUM));
		write_reg(brmg_pkg::REG_GAIN, 32'h7FFF_FFFF);
		write_reg(brmg_pkg::REG_OFFSET, 32'h8000_0000);
		write_reg(brmg_pkg::REG_IN_MISSING, 32'h7F);
		write_reg(brmg_pkg::REG_IN_BAD, 32'h7F);
		write_reg(brmg_pkg::REG_OUT_MISSING, 32'hFF);
		write_reg(brmg_pkg::REG_OUT_BAD, 32'h00);
		end_writes();
		queue_item(brmg_pkg::CMD_MERGE, 16'hAAAA, 8'h7F, 1'b0);
		queue_item(brmg_pkg::CMD_MERGE, 16'h5555, 8'h02, 1'b0);
		queue_item(brmg_pkg::CMD_LOAD, 16'h1234, 8'h02, 1'b0);
		queue_item(brmg_pkg::CMD_MERGE, 16'h1234, 8'h00, 1'b0);
		queue_item(brmg_pkg::CMD_MERGE, 16'h0000, 8'h7F, 1'b0);
		wait_drained();

		// Unused merge mode, most negative gain, largest offset, and the unused register index.
		write_reg(brmg_pkg::REG_MERGE_MODE, 32'(MODE_SPARE));
		write_reg(brmg_pkg::REG_GAIN, 32'h8000_0000);
		write_reg(brmg_pkg::REG_OFFSET, 32'h7FFF_FFFF);
		write_reg(brmg_pkg::REG_IN_MISSING, 32'hFF);
		write_reg(brmg_pkg::REG_IN_BAD, 32'h00);
		write_reg(brmg_pkg::REG_OUT_MISSING, 32'h02);
		write_reg(brmg_pkg::REG_OUT_BAD, 32'hFE);
		write_reg(REG_SPARE, $urandom());
		end_writes();
		queue_item(brmg_pkg::CMD_MERGE, 16'h5555, 8'h01, 1'b0);
		queue_item(brmg_pkg::CMD_MERGE, 16'hFFFF, 8'hFF, 1'b0);
		queue_item(brmg_pkg::CMD_MERGE, 16'hFFFF, 8'h00, 1'b0);
		queue_item(brmg_pkg::CMD_MERGE, 16'hAAAA, 8'h10, 1'b0);
		queue_item(CMD_SPARE, 16'hFFFF, 8'h00, 1'b0);
		queue_item(brmg_pkg::CMD_READ, 16'h5555, 8'hFF, 1'b0);
		wait_drained();

		// Random phases, rotating through the idling patterns.
		for (p = 0; p < RANDOM_PHASES; p++) begin
			random_config();
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
				default: begin send_idle_pct = 31; recv_stall_pct = 31; end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++)
				add_random_item((p == 0 && i == 40) || $urandom_range(59) == 0);
			wait_drained();
		end

		$display("Covered %0d loads, %0d merges and %0d reads over %0d settings phases.",
			loads_done, merges_done, reads_done, phases_run);
		$display("Checked %0d results against the predicted grid contents.", results_seen);
		if (fail_cnt == 0)
			$display("** byte_rescale_merge_grid: PASSED **");
		else
			$display("** byte_rescale_merge_grid: FAILED **");
		$finish;
	end

endmodule
